// ===== src/edc_pkg.sv =====
// Shared types and calendar constants for the day-count-to-date converter.
package edc_pkg;

  localparam int unsigned DAY_W   = 22;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned MDAY_W  = 5;
  localparam int unsigned LEN_W   = 9;
  localparam int unsigned R400_W  = 9;

  localparam logic [YEAR_W-1:0]  EPOCH_RESET = YEAR_W'(1900);
  localparam logic [YEAR_W-1:0]  CYCLE_400   = YEAR_W'(400);
  localparam logic [R400_W-1:0]  R400_LAST   = R400_W'(399);
  localparam logic [MONTH_W-1:0] JANUARY     = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] FEBRUARY    = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] DECEMBER    = MONTH_W'(12);
  localparam logic [MDAY_W-1:0]  LAST_MDAY   = MDAY_W'(31);

  typedef struct packed {
    logic                is_month;
    logic [1:0]          year_lo;
    logic [R400_W-1:0]   rem400;
    logic [MONTH_W-1:0]  month;
  } len_query_t;

  function automatic logic [LEN_W-1:0] days_in_month(input logic [MONTH_W-1:0] m);
    logic [LEN_W-1:0] d;
    unique case (m)
      4'd4, 4'd6, 4'd9, 4'd11: d = LEN_W'(30);
      4'd2:                    d = LEN_W'(28);
      default:                 d = LEN_W'(31);
    endcase
    return d;
  endfunction

endpackage

// ===== src/epoch_day_count_to_date.sv =====
// Day count to Gregorian date converter: top level with sequencer and shared subtractor.
// An accepted beat first finds the base year's place in the 400-year cycle by taking away 400
// repeatedly, then steps whole years from the base year and then whole months; a single
// subtractor removes one year or one month a cycle. The result is loaded into the output
// register from the finishing state, after which the next beat can be accepted. A base
// year above MAX_YEAR skips the stepping and goes straight to the finishing state. The
// input is not ready while a conversion runs, nor while a finished result waits for the
// output register to free up. Counts past 31 December of MAX_YEAR, or a base year above
// MAX_YEAR, give MAX_YEAR-12-31 with the error flag set. Write cfg_wr_en only while idle.
module epoch_day_count_to_date #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [13:0] cfg_wr_data,    // base year
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [21:0] day_count, [23:22] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [13:0] year, [17:14] month, [22:18] day_of_month
  output logic        m_axis_tuser    // range_error
);

  localparam logic [edc_pkg::YEAR_W-1:0] MAX_Y = edc_pkg::YEAR_W'(MAX_YEAR);

  typedef enum logic [2:0] {IDLE, REDUCE, YEARS, MONTHS, FINISH} state_t;

  state_t                         state;
  logic [edc_pkg::YEAR_W-1:0]     base_year;
  logic [edc_pkg::DAY_W-1:0]      days;
  logic [edc_pkg::YEAR_W-1:0]     year;
  logic [edc_pkg::YEAR_W-1:0]     rem400;
  logic [edc_pkg::MONTH_W-1:0]    month;
  logic                           sat;

  edc_pkg::len_query_t            query;
  logic [edc_pkg::LEN_W-1:0]      len;
  logic [edc_pkg::DAY_W:0]        diff;
  logic                           fits;
  logic                           out_free;

  assign query.is_month = (state == MONTHS);
  assign query.year_lo  = year[1:0];
  assign query.rem400   = rem400[edc_pkg::R400_W-1:0];
  assign query.month    = month;

  edc_len u_len (
    .query (query),
    .len   (len)
  );

  assign diff     = {1'b0, days} - (edc_pkg::DAY_W+1)'(len);
  assign fits     = !diff[edc_pkg::DAY_W];
  assign out_free = !m_axis_tvalid || m_axis_tready;

  assign s_axis_tready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      base_year     <= edc_pkg::EPOCH_RESET;
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      m_axis_tuser  <= 1'b0;
      sat           <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        base_year <= cfg_wr_data;
      end
      if (m_axis_tvalid && m_axis_tready && state != FINISH) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (s_axis_tvalid) begin
            days   <= s_axis_tdata[edc_pkg::DAY_W-1:0];
            year   <= base_year;
            rem400 <= base_year;
            month  <= edc_pkg::JANUARY;
            sat    <= (base_year > MAX_Y);
            state  <= (base_year > MAX_Y) ? FINISH : REDUCE;
          end
        end
        REDUCE: begin
          if (rem400 >= edc_pkg::CYCLE_400) begin
            rem400 <= rem400 - edc_pkg::CYCLE_400;
          end else begin
            state <= YEARS;
          end
        end
        YEARS: begin
          if (fits) begin
            if (year >= MAX_Y) begin
              sat   <= 1'b1;
              state <= FINISH;
            end else begin
              days   <= diff[edc_pkg::DAY_W-1:0];
              year   <= year + 1'b1;
              rem400 <= (rem400[edc_pkg::R400_W-1:0] == edc_pkg::R400_LAST) ?
                        '0 : rem400 + 1'b1;
            end
          end else begin
            state <= MONTHS;
          end
        end
        MONTHS: begin
          if (month < edc_pkg::DECEMBER && fits) begin
            days  <= diff[edc_pkg::DAY_W-1:0];
            month <= month + 1'b1;
          end else begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= sat;
            if (sat) begin
              m_axis_tdata <= {1'b0, edc_pkg::LAST_MDAY, edc_pkg::DECEMBER, MAX_Y};
            end else begin
              m_axis_tdata <= {1'b0, edc_pkg::MDAY_W'(days) + 1'b1, month, year};
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== src/edc_len.sv =====
// Length in days of the current year or month, with the Gregorian leap rule.
module edc_len (
  input  edc_pkg::len_query_t          query,
  output logic [edc_pkg::LEN_W-1:0]    len
);

  logic leap;

  assign leap = (query.year_lo == 2'd0) &&
                (query.rem400 != edc_pkg::R400_W'(100)) &&
                (query.rem400 != edc_pkg::R400_W'(200)) &&
                (query.rem400 != edc_pkg::R400_W'(300));

  always_comb begin
    if (!query.is_month) begin
      len = leap ? edc_pkg::LEN_W'(366) : edc_pkg::LEN_W'(365);
    end else if (query.month == edc_pkg::FEBRUARY && leap) begin
      len = edc_pkg::LEN_W'(29);
    end else begin
      len = edc_pkg::days_in_month(query.month);
    end
  end

endmodule
